### rtl/rps_pkg.sv
`default_nettype none

package rps_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VAL_W    = 17;
    localparam int RES_W    = 18;
    localparam int MAP_W    = 18;
    localparam int INC_W    = 20;
    localparam int FRAME_W  = 16;
    localparam int DIV_W    = 9;
    localparam int OUT_COST_W = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 104;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_SIDE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [FRAME_W-1:0] BLOCK_SIZE_RESET    = 16'd4096;
    localparam logic [1:0]         CHANNEL_COUNT_RESET = 2'd2;
    localparam logic [1:0]         CHANNEL_STEREO      = 2'd2;

    typedef struct packed {
        logic                      valid;
        logic                      close;
        logic                      skip;
        logic                      has1;
        logic [MAP_W-1:0]          m0;
        logic [MAP_W-1:0]          m1;
        logic signed [VAL_W-1:0]   fv0;
        logic signed [VAL_W-1:0]   fv1;
        logic [FRAME_W-1:0]        frames;
    } rps_tok_t;

endpackage

`default_nettype wire

### rtl/rice_parameter_selector.sv
// channel | ports                  | payload
// input   | s_tvalid/tready/tlast  | sample_left, sample_right; end_of_stream on tlast
// result  | m_tvalid/tready        | divisor, cost, first values, frame count
// config  | cfg_we/index/data      | block_size, mid_side_enable, channel_count
//
// one frame per cycle while s_tready is high; a frame runs through a
// front stage and one cell per candidate divisor, and the block result
// is registered in the output register from the last cell's closing frame.
// synchronous active-low reset clears all counters and cost sums at once.
// s_tready drops only while a block result waits in the output register
// with m_tready low and the chain's last cell holds the next closing frame.
`default_nettype none

module rice_parameter_selector
    import rps_pkg::*;
#(
    parameter int NUM_CANDIDATES = 9,
    parameter int COST_BITS      = 40
)
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_DATA_W-1:0]    s_tdata,   // sample_left, sample_right
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // best_divisor, best_cost_bits, first_value_ch0, first_value_ch1, frames_in_block
    output logic [M_DATA_W-1:0]         m_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (NUM_CANDIDATES > 1) ? $clog2(NUM_CANDIDATES) : 1;
    localparam logic [63:0] OUT_COST_MAX = (64'd1 << OUT_COST_W) - 64'd1;

    logic [FRAME_W-1:0] block_size_reg;
    logic               mid_side_reg;
    logic [1:0]         chan_count_reg;

    logic advance, in_fire, last_close;

    rps_tok_t             tok_chain  [NUM_CANDIDATES+1];
    logic [COST_BITS-1:0] cost_chain [NUM_CANDIDATES+1];
    logic [IDX_W-1:0]     idx_chain  [NUM_CANDIDATES+1];

    logic                        out_valid_reg;
    logic [DIV_W-1:0]            out_div_reg, out_div_next;
    logic [OUT_COST_W-1:0]       out_cost_reg, out_cost_next;
    logic signed [VAL_W-1:0]     out_fv0_reg, out_fv1_reg;
    logic [FRAME_W-1:0]          out_frames_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= BLOCK_SIZE_RESET;
            mid_side_reg   <= 1'b0;
            chan_count_reg <= CHANNEL_COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BLOCK_SIZE:    block_size_reg <= cfg_data;
                REG_MID_SIDE:      mid_side_reg   <= cfg_data[0];
                REG_CHANNEL_COUNT: chan_count_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign last_close = tok_chain[NUM_CANDIDATES].valid && tok_chain[NUM_CANDIDATES].close;
    assign advance    = !(out_valid_reg && !m_tready && last_close);
    assign s_tready   = advance;
    assign in_fire    = s_tvalid && s_tready;

    rps_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .in_fire         (in_fire),
        .sample_left     (s_tdata[15:0]),
        .sample_right    (s_tdata[31:16]),
        .end_of_stream   (s_tlast),
        .block_size      (block_size_reg),
        .mid_side_enable (mid_side_reg),
        .channel_count   (chan_count_reg),
        .tok_out         (tok_chain[0])
    );

    assign cost_chain[0] = '0;
    assign idx_chain[0]  = '0;

    for (genvar k = 0; k < NUM_CANDIDATES; k++) begin : g_cell
        rps_cell #(
            .K         (k),
            .IDX_W     (IDX_W),
            .COST_BITS (COST_BITS)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .advance      (advance),
            .tok_in       (tok_chain[k]),
            .min_cost_in  (cost_chain[k]),
            .min_idx_in   (idx_chain[k]),
            .tok_out      (tok_chain[k+1]),
            .min_cost_out (cost_chain[k+1]),
            .min_idx_out  (idx_chain[k+1])
        );
    end

    always_comb begin
        if (32'(idx_chain[NUM_CANDIDATES]) < DIV_W) begin
            out_div_next = DIV_W'(1) << idx_chain[NUM_CANDIDATES];
        end else begin
            out_div_next = '0;
        end
    end

    if (COST_BITS > OUT_COST_W) begin : g_cost_clamp
        always_comb begin
            if (cost_chain[NUM_CANDIDATES] > COST_BITS'(OUT_COST_MAX)) begin
                out_cost_next = OUT_COST_MAX[OUT_COST_W-1:0];
            end else begin
                out_cost_next = OUT_COST_W'(cost_chain[NUM_CANDIDATES]);
            end
        end
    end else begin : g_cost_ext
        assign out_cost_next = OUT_COST_W'(cost_chain[NUM_CANDIDATES]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && last_close) begin
            out_valid_reg  <= 1'b1;
            out_div_reg    <= out_div_next;
            out_cost_reg   <= out_cost_next;
            out_fv0_reg    <= tok_chain[NUM_CANDIDATES].fv0;
            out_fv1_reg    <= tok_chain[NUM_CANDIDATES].fv1;
            out_frames_reg <= tok_chain[NUM_CANDIDATES].frames;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_frames_reg, out_fv1_reg, out_fv0_reg, out_cost_reg,
                       out_div_reg};

    a_div_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($onehot(out_div_reg) || NUM_CANDIDATES > DIV_W))
        else $error("divisor is not a single power of two");

    a_frames_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_frames_reg != '0))
        else $error("closed block reports no frames");

    a_single_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_frames_reg == FRAME_W'(1))
            |-> (out_cost_reg == '0 && out_div_reg == DIV_W'(1)))
        else $error("single frame block carries cost");

endmodule

`default_nettype wire

### rtl/rps_front.sv
`default_nettype none

module rps_front
    import rps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire logic                  in_fire,
    input  wire logic [SAMPLE_W-1:0]   sample_left,
    input  wire logic [SAMPLE_W-1:0]   sample_right,
    input  wire logic                  end_of_stream,
    input  wire logic [FRAME_W-1:0]    block_size,
    input  wire logic                  mid_side_enable,
    input  wire logic [1:0]            channel_count,
    output rps_tok_t                   tok_out
);

    logic signed [VAL_W-1:0] prev0_reg, prev1_reg, prev0_next, prev1_next;
    logic signed [VAL_W-1:0] first0_reg, first1_reg, first0_next, first1_next;
    logic [FRAME_W-1:0]      cnt_reg, cnt_next;
    rps_tok_t                tok_reg, tok_next;

    logic                    stereo;
    logic signed [VAL_W-1:0] l, r, a, b;
    logic signed [RES_W-1:0] d0, d1;
    logic [FRAME_W-1:0]      cnt_inc, limit;
    logic                    skip, close;

    always_comb begin
        stereo  = (channel_count == CHANNEL_STEREO);
        l       = VAL_W'(signed'(sample_left));
        r       = stereo ? VAL_W'(signed'(sample_right)) : '0;
        if (stereo && mid_side_enable) begin
            a = l + r;
            b = l - r;
        end else begin
            a = l;
            b = r;
        end
        skip    = (cnt_reg == '0);
        d0      = RES_W'(a) - RES_W'(prev0_reg);
        d1      = RES_W'(b) - RES_W'(prev1_reg);
        cnt_inc = cnt_reg + FRAME_W'(1);
        limit   = (block_size == '0) ? FRAME_W'(1) : block_size;
        close   = end_of_stream || (cnt_inc >= limit);

        tok_next.valid  = in_fire;
        tok_next.close  = close;
        tok_next.skip   = skip;
        tok_next.has1   = stereo;
        tok_next.m0     = {d0[RES_W-2:0], 1'b0} ^ {MAP_W{d0[RES_W-1]}};
        tok_next.m1     = {d1[RES_W-2:0], 1'b0} ^ {MAP_W{d1[RES_W-1]}};
        tok_next.fv0    = skip ? a : first0_reg;
        tok_next.fv1    = stereo ? (skip ? b : first1_reg) : '0;
        tok_next.frames = cnt_inc;

        prev0_next  = a;
        prev1_next  = b;
        first0_next = skip ? a : first0_reg;
        first1_next = skip ? b : first1_reg;
        cnt_next    = close ? '0 : cnt_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev0_reg     <= '0;
            prev1_reg     <= '0;
            first0_reg    <= '0;
            first1_reg    <= '0;
            cnt_reg       <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            if (in_fire) begin
                prev0_reg  <= prev0_next;
                prev1_reg  <= prev1_next;
                first0_reg <= first0_next;
                first1_reg <= first1_next;
                cnt_reg    <= cnt_next;
            end
            if (advance) begin
                tok_reg <= tok_next;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

### rtl/rps_cell.sv
`default_nettype none

module rps_cell
    import rps_pkg::*;
#(
    parameter int K         = 0,
    parameter int IDX_W     = 4,
    parameter int COST_BITS = 40
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  advance,
    input  wire rps_tok_t              tok_in,
    input  wire logic [COST_BITS-1:0]  min_cost_in,
    input  wire logic [IDX_W-1:0]      min_idx_in,
    output rps_tok_t                   tok_out,
    output logic [COST_BITS-1:0]       min_cost_out,
    output logic [IDX_W-1:0]           min_idx_out
);

    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    logic [COST_BITS-1:0] acc_reg, acc_next;
    rps_tok_t             tok_reg;
    logic [COST_BITS-1:0] min_cost_reg, min_cost_next;
    logic [IDX_W-1:0]     min_idx_reg, min_idx_next;

    logic [INC_W-1:0]     c0, c1, inc;
    logic [COST_BITS:0]   sum;
    logic [COST_BITS-1:0] acc_new;
    logic                 take;

    always_comb begin
        c0      = INC_W'(tok_in.m0 >> K) + INC_W'(K + 1);
        c1      = INC_W'(tok_in.m1 >> K) + INC_W'(K + 1);
        inc     = tok_in.skip ? '0 : (c0 + (tok_in.has1 ? c1 : '0));
        sum     = {1'b0, acc_reg} + (COST_BITS + 1)'(inc);
        acc_new = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
        // ties keep the earlier, smaller divisor
        take    = (K == 0) || (acc_new < min_cost_in);

        acc_next      = tok_in.close ? '0 : acc_new;
        min_cost_next = take ? acc_new : min_cost_in;
        min_idx_next  = take ? IDX_W'(K) : min_idx_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            if (tok_in.valid) begin
                acc_reg <= acc_next;
            end
            tok_reg      <= tok_in;
            min_cost_reg <= min_cost_next;
            min_idx_reg  <= min_idx_next;
        end
    end

    assign tok_out      = tok_reg;
    assign min_cost_out = min_cost_reg;
    assign min_idx_out  = min_idx_reg;

endmodule

`default_nettype wire
